// ===== hw/rtl/rqr_pkg.sv =====
// ============================================================================
// rqr_pkg: shared types and constants for the ready queue
// Command and result word layouts, operation codes and table sizes.
// ============================================================================
package rqr_pkg;

    localparam int ENTRIES = 16;
    localparam int SLOT_W  = 4;
    localparam int CNT_W   = 5;

    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_POP    = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_QUERY  = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [SLOT_W-1:0]  entry_id;
    } t_cmd;

    typedef struct packed {
        logic [SLOT_W-1:0]  popped_id;
        logic               pop_valid;
        logic               queue_empty;
        logic [CNT_W-1:0]   entry_count;
    } t_res;

    // Command word handed from the input register to the list core.
    typedef struct packed {
        logic               go;
        t_cmd               cmd;
    } t_issue;

endpackage

// ===== hw/rtl/rqr_core.sv =====
// ============================================================================
// rqr_core: linked-list state and its update logic
// Holds the link tables, membership bits, head, tail and count; applies one
// command per cycle and presents its result combinationally.
// ============================================================================
module rqr_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rqr_pkg::t_issue    i_issue,
    output rqr_pkg::t_res      o_res
);

    logic [rqr_pkg::SLOT_W-1:0] r_next [rqr_pkg::ENTRIES];
    logic [rqr_pkg::SLOT_W-1:0] r_prev [rqr_pkg::ENTRIES];
    logic [rqr_pkg::SLOT_W-1:0] n_next [rqr_pkg::ENTRIES];
    logic [rqr_pkg::SLOT_W-1:0] n_prev [rqr_pkg::ENTRIES];
    logic [rqr_pkg::ENTRIES-1:0] r_member;
    logic [rqr_pkg::ENTRIES-1:0] n_member;
    logic [rqr_pkg::SLOT_W-1:0] r_head;
    logic [rqr_pkg::SLOT_W-1:0] n_head;
    logic [rqr_pkg::SLOT_W-1:0] r_tail;
    logic [rqr_pkg::SLOT_W-1:0] n_tail;
    logic [rqr_pkg::CNT_W-1:0]  r_occ;
    logic [rqr_pkg::CNT_W-1:0]  n_occ;

    logic [rqr_pkg::SLOT_W-1:0] slot;
    logic [rqr_pkg::SLOT_W-1:0] after;
    logic [rqr_pkg::SLOT_W-1:0] prior;
    logic                       in_range;
    logic                       at_head;
    logic                       at_tail;
    logic                       want_unlink;
    logic                       do_unlink;
    logic                       do_append;
    logic                       do_pop;

    // Pop works on the head; the other operations on the named slot.
    assign slot     = (i_issue.cmd.mode == rqr_pkg::MODE_POP) ? r_head
                                                             : i_issue.cmd.entry_id;
    assign in_range = (int'(slot) < rqr_pkg::ENTRIES);
    assign at_head  = (r_head == slot);
    assign at_tail  = (r_tail == slot);
    assign after    = at_tail ? '0 : r_next[slot];
    assign prior    = at_head ? '0 : r_prev[slot];

    always_comb begin
        want_unlink = 1'b0;
        do_append   = 1'b0;
        do_pop      = 1'b0;
        case (i_issue.cmd.mode)
            rqr_pkg::MODE_PUSH: begin
                want_unlink = in_range;
                do_append   = in_range;
            end
            rqr_pkg::MODE_POP: begin
                do_pop      = (r_occ != '0);
                want_unlink = do_pop;
            end
            rqr_pkg::MODE_REMOVE: begin
                want_unlink = in_range;
            end
            default: begin
            end
        endcase
    end

    assign do_unlink = want_unlink && in_range && r_member[slot] && (r_occ != '0);

    always_comb begin
        n_next   = r_next;
        n_prev   = r_prev;
        n_member = r_member;
        n_head   = r_head;
        n_tail   = r_tail;
        n_occ    = r_occ;

        if (i_issue.go && do_unlink) begin
            if (at_head) begin
                n_head = after;
            end else begin
                n_next[prior] = after;
            end
            if (at_tail) begin
                n_tail = prior;
            end else begin
                n_prev[after] = prior;
            end
            n_member[slot] = 1'b0;
            n_next[slot]   = '0;
            n_prev[slot]   = '0;
            n_occ          = r_occ - 1'b1;
            if (n_occ == '0) begin
                n_head = '0;
                n_tail = '0;
            end
        end

        // Append after any unlink, so a queued slot moves to the tail.
        if (i_issue.go && do_append) begin
            if (n_occ == '0) begin
                n_head       = slot;
                n_next[slot] = '0;
                n_prev[slot] = '0;
            end else begin
                n_prev[slot]   = n_tail;
                n_next[slot]   = '0;
                n_next[n_tail] = slot;
            end
            n_tail         = slot;
            n_member[slot] = 1'b1;
            n_occ          = n_occ + 1'b1;
        end
    end

    always_comb begin
        o_res.popped_id   = do_pop ? r_head : '0;
        o_res.pop_valid   = do_pop;
        o_res.queue_empty = (n_occ == '0);
        o_res.entry_count = n_occ;
    end

    // Link tables carry no reset: an entry is read only after it was written.
    always_ff @(posedge i_clk) begin
        r_next <= n_next;
        r_prev <= n_prev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_member <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_occ    <= '0;
        end else begin
            r_member <= n_member;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_occ    <= n_occ;
        end
    end

endmodule

// ===== hw/rtl/ready_queue_with_removal.sv =====
// ============================================================================
// ready_queue_with_removal: FIFO ready queue of task slots with removal
// Doubly linked list of slots with push-to-tail, pop-head, remove and query.
// ============================================================================
// Usage: drive a command word on i_cmd with start high; it is taken at any
// rising edge where start is high and busy is low. busy is low at all times
// outside reset, so one command may be issued every cycle. Each command gives
// exactly one result word on o_res, marked by o_done for a single cycle;
// results come back in command order. The receiver cannot stall the block,
// so it must take o_res whenever o_done is high. Throughput is one command
// per cycle outside reset. A command goes into the command register, then
// through the list update into the result register. Each result reports
// the queue's emptiness and count after that command. A push of a slot
// already queued moves it to the tail; a pop of an empty queue returns
// pop_valid low and popped_id zero; a remove of a slot not queued changes
// nothing. No clearing pass runs after reset.
// ============================================================================
module ready_queue_with_removal (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  rqr_pkg::t_cmd   i_cmd,
    output logic            o_done,
    output rqr_pkg::t_res   o_res
);

    logic             accept;
    logic             r_go;
    rqr_pkg::t_cmd    r_cmd;
    rqr_pkg::t_issue  issue;
    rqr_pkg::t_res    core_res;
    logic             r_done;
    rqr_pkg::t_res    r_res;

    // Hold off commands only while reset is applied.
    assign busy   = ~i_rst_n;
    assign accept = start && !busy;

    // Command register: capture the word on accept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go <= 1'b0;
        end else begin
            r_go <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
        end
    end

    assign issue.go  = r_go;
    assign issue.cmd = r_cmd;

    // List core: update head, tail, links and count in one pass.
    rqr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_issue (issue),
        .o_res   (core_res)
    );

    // Result register: capture the word; o_done marks it for exactly one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_go) begin
            r_res <= core_res;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== hw/rtl/rqr_checker.sv =====
// ============================================================================
// rqr_checker: port-level checks for the ready queue
// Watches command and result ports for latency, popped id and count consistency.
// ============================================================================
module rqr_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic            busy,
    input  logic            o_done,
    input  rqr_pkg::t_res   o_res
);

    // Every taken command yields its result strobe on o_done.
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("result missing two cycles after command");

    a_empty_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_res.queue_empty == (o_res.entry_count == '0)))
        else $error("empty flag disagrees with count");

    a_no_pop_id : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_res.pop_valid) |-> (o_res.popped_id == '0))
        else $error("popped id nonzero without pop");

    // Back-to-back results come from back-to-back commands: count moves by at most one.
    a_count_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(o_done)) |->
            (({1'b0, o_res.entry_count} == {1'b0, $past(o_res.entry_count)}) ||
             ({1'b0, o_res.entry_count} == {1'b0, $past(o_res.entry_count)} + 1'b1) ||
             ({1'b0, o_res.entry_count} + 1'b1 == {1'b0, $past(o_res.entry_count)})))
        else $error("count moved by more than one");

endmodule

bind ready_queue_with_removal rqr_checker u_rqr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_res   (o_res)
);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking bench for ready_queue_with_removal
// Drives push, pop, remove and query words through the start/busy handshake
// and compares every result word with a local model of the linked-list queue.
// Three pacing phases: light sender gaps, heavy sender gaps, back to back.
// ============================================================================
module tb;

    localparam int WATCHDOG_LIMIT = 200;  // cycles with no word moving
    localparam int DRAIN_CYCLES   = 4;    // extra edges to catch stray results

    typedef logic [rqr_pkg::SLOT_W-1:0] t_slot;

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    rqr_pkg::t_cmd  i_cmd;
    logic           o_done;
    rqr_pkg::t_res  o_res;

    ready_queue_with_removal u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Queue model: link tables, membership bits, head, tail and count.
    // Link entries are only read for queued slots with a neighbor on that
    // side, so their reset value never matters.
    // ------------------------------------------------------------------------
    t_slot                      link_next [rqr_pkg::ENTRIES];
    t_slot                      link_prev [rqr_pkg::ENTRIES];
    bit                         queued    [rqr_pkg::ENTRIES];
    t_slot                      head_id;
    t_slot                      tail_id;
    logic [rqr_pkg::CNT_W-1:0]  depth;

    rqr_pkg::t_res pending_results [$];   // results owed by the block, oldest first

    int n_errors    = 0;
    int n_sent      = 0;
    int n_checked   = 0;
    int n_pop_hit   = 0;
    int n_pop_empty = 0;
    int n_moves     = 0;
    int n_full      = 0;
    int idle_cycles = 0;

    // Take a slot out of the list; do nothing if it is not queued.
    function automatic void unlink_slot(input t_slot s);
        bit    at_head;
        bit    at_tail;
        t_slot after;
        t_slot prior;
        if (!queued[s] || depth == 0) return;
        at_head = (head_id == s);
        at_tail = (tail_id == s);
        after   = at_tail ? '0 : link_next[s];
        prior   = at_head ? '0 : link_prev[s];
        if (at_head) head_id = after;
        else         link_next[prior] = after;
        if (at_tail) tail_id = prior;
        else         link_prev[after] = prior;
        queued[s]    = 1'b0;
        link_next[s] = '0;
        link_prev[s] = '0;
        depth--;
        // Last slot gone: park head and tail at zero.
        if (depth == 0) begin
            head_id = '0;
            tail_id = '0;
        end
    endfunction

    // Apply one accepted word to the model and return the result it owes.
    function automatic rqr_pkg::t_res predict_queue_result(input rqr_pkg::t_cmd c);
        rqr_pkg::t_res r;
        r = '0;
        case (c.mode)
            rqr_pkg::MODE_PUSH: begin
                // A queued slot moves to the tail: unlink first, then append.
                if (queued[c.entry_id]) n_moves++;
                unlink_slot(c.entry_id);
                if (depth == 0) begin
                    head_id = c.entry_id;
                    tail_id = c.entry_id;
                    link_prev[c.entry_id] = '0;
                end else begin
                    link_prev[c.entry_id] = tail_id;
                    link_next[tail_id]    = c.entry_id;
                    tail_id               = c.entry_id;
                end
                link_next[c.entry_id] = '0;
                queued[c.entry_id]    = 1'b1;
                depth++;
                if (depth == rqr_pkg::ENTRIES) n_full++;
            end
            rqr_pkg::MODE_POP: begin
                // Pop of an empty queue reports nothing and changes nothing.
                if (depth != 0) begin
                    r.popped_id = head_id;
                    r.pop_valid = 1'b1;
                    unlink_slot(head_id);
                    n_pop_hit++;
                end else begin
                    n_pop_empty++;
                end
            end
            rqr_pkg::MODE_REMOVE: unlink_slot(c.entry_id);
            default: ;
        endcase
        r.queue_empty = (depth == 0);
        r.entry_count = depth;
        return r;
    endfunction

    function automatic rqr_pkg::t_cmd make_cmd(input rqr_pkg::t_mode m,
                                               input t_slot id);
        rqr_pkg::t_cmd c;
        c.mode     = m;
        c.entry_id = id;
        return c;
    endfunction

    // Any slot number, drawn uniformly.
    function automatic t_slot any_slot();
        return t_slot'($urandom_range(rqr_pkg::ENTRIES - 1));
    endfunction

    // Pick a queued slot at random; any slot if the queue is empty.
    function automatic t_slot any_member();
        t_slot s;
        s = any_slot();
        if (depth == 0) return s;
        while (!queued[s]) s = s + 1'b1;
        return s;
    endfunction

    task automatic report_mismatch(input string what);
        n_errors++;
        $display("[%0t] mismatch #%0d: %s", $realtime, n_errors, what);
    endtask

    // ------------------------------------------------------------------------
    // Sender: called at a falling edge. Raise start with the word, hold it
    // until an edge sees busy low, record the owed result, and return at the
    // next falling edge with start still high. The caller lowers start only
    // when it idles, so start never drops and rises in one time step.
    // ------------------------------------------------------------------------
    task automatic send_word(input rqr_pkg::t_cmd c);
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(predict_queue_result(c));
        n_sent++;
        @(negedge i_clk);
    endtask

    // Idle the sender so that about idle_pct cycles in a hundred carry no word.
    task automatic sender_gap(input int idle_pct);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    // ------------------------------------------------------------------------
    // Checker: every strobed result word is matched against the oldest owed
    // result, field by field. A word with nothing owed is a failure too.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        rqr_pkg::t_res want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result word with none owed: %h", o_res));
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (o_res.popped_id !== want.popped_id)
                    report_mismatch($sformatf("popped_id got %0d want %0d",
                                              o_res.popped_id, want.popped_id));
                if (o_res.pop_valid !== want.pop_valid)
                    report_mismatch($sformatf("pop_valid got %b want %b",
                                              o_res.pop_valid, want.pop_valid));
                if (o_res.queue_empty !== want.queue_empty)
                    report_mismatch($sformatf("queue_empty got %b want %b",
                                              o_res.queue_empty, want.queue_empty));
                if (o_res.entry_count !== want.entry_count)
                    report_mismatch($sformatf("entry_count got %0d want %0d",
                                              o_res.entry_count, want.entry_count));
            end
        end
    end

    // Watchdog: count edges at which no word moves in either direction.
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles", idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Empty queue out of reset: query, pop of nothing, remove of an absent slot.
    task automatic test_idle_queue();
        send_word(make_cmd(rqr_pkg::MODE_QUERY, 4'd0));
        send_word(make_cmd(rqr_pkg::MODE_POP, 4'd15));
        send_word(make_cmd(rqr_pkg::MODE_REMOVE, 4'd5));
    endtask

    // Hand-picked edits: moves to tail, removes at middle, head and tail,
    // last slot leaving by pop and by remove, refill after the list empties.
    task automatic test_list_edits();
        send_word(make_cmd(rqr_pkg::MODE_PUSH, 4'd0));
        send_word(make_cmd(rqr_pkg::MODE_PUSH, 4'd15));
        send_word(make_cmd(rqr_pkg::MODE_PUSH, 4'd7));
        send_word(make_cmd(rqr_pkg::MODE_PUSH, 4'd0));    // head moves to tail
        send_word(make_cmd(rqr_pkg::MODE_PUSH, 4'd0));    // tail pushed again stays put
        send_word(make_cmd(rqr_pkg::MODE_REMOVE, 4'd7));  // middle
        send_word(make_cmd(rqr_pkg::MODE_REMOVE, 4'd15)); // head
        send_word(make_cmd(rqr_pkg::MODE_PUSH, 4'd9));
        send_word(make_cmd(rqr_pkg::MODE_REMOVE, 4'd9));  // tail
        send_word(make_cmd(rqr_pkg::MODE_QUERY, 4'd15));
        send_word(make_cmd(rqr_pkg::MODE_POP, 4'd0));     // last slot popped
        send_word(make_cmd(rqr_pkg::MODE_PUSH, 4'd3));
        send_word(make_cmd(rqr_pkg::MODE_REMOVE, 4'd3));  // last slot removed
        send_word(make_cmd(rqr_pkg::MODE_POP, 4'd10));    // empty again
        send_word(make_cmd(rqr_pkg::MODE_PUSH, 4'd15));
        send_word(make_cmd(rqr_pkg::MODE_POP, 4'd0));
    endtask

    // Fill every slot in shuffled order, churn at full, then drain to empty.
    task automatic test_full_table(input int idle_pct);
        t_slot order [rqr_pkg::ENTRIES];
        t_slot tmp;
        int    j;
        for (int i = 0; i < rqr_pkg::ENTRIES; i++) order[i] = t_slot'(i);
        for (int i = rqr_pkg::ENTRIES - 1; i > 0; i--) begin
            j        = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < rqr_pkg::ENTRIES; i++) begin
            send_word(make_cmd(rqr_pkg::MODE_PUSH, order[i]));
            sender_gap(idle_pct);
        end
        repeat (6) begin
            send_word(make_cmd(rqr_pkg::MODE_PUSH, any_member()));
            sender_gap(idle_pct);
        end
        send_word(make_cmd(rqr_pkg::MODE_QUERY, any_slot()));
        while (depth != 0) begin
            if ($urandom_range(1))
                send_word(make_cmd(rqr_pkg::MODE_POP, any_slot()));
            else
                send_word(make_cmd(rqr_pkg::MODE_REMOVE, any_member()));
            sender_gap(idle_pct);
        end
        send_word(make_cmd(rqr_pkg::MODE_POP, any_slot()));
        sender_gap(idle_pct);
    endtask

    // Random traffic in segments that lean toward filling or draining, so
    // the count sweeps between empty and full. Removes mostly hit a queued
    // slot; the rest probe slots that may be absent.
    task automatic test_random_traffic(input int n_words, input int idle_pct);
        bit             filling;
        int             r;
        rqr_pkg::t_mode m;
        t_slot          id;
        for (int k = 0; k < n_words; k++) begin
            if (k % 40 == 0) filling = ($urandom_range(1) != 0);
            r = $urandom_range(99);
            if (filling)
                m = (r < 60) ? rqr_pkg::MODE_PUSH : (r < 75) ? rqr_pkg::MODE_POP :
                    (r < 92) ? rqr_pkg::MODE_REMOVE : rqr_pkg::MODE_QUERY;
            else
                m = (r < 25) ? rqr_pkg::MODE_PUSH : (r < 60) ? rqr_pkg::MODE_POP :
                    (r < 90) ? rqr_pkg::MODE_REMOVE : rqr_pkg::MODE_QUERY;
            id = any_slot();
            if (m == rqr_pkg::MODE_REMOVE && $urandom_range(99) < 75) id = any_member();
            send_word(make_cmd(m, id));
            sender_gap(idle_pct);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence: reset once, directed cases, then three pacing phases.
    // ------------------------------------------------------------------------
    initial begin
        int idle_pct [3];
        idle_pct = '{8, 62, 0};
        for (int i = 0; i < rqr_pkg::ENTRIES; i++) begin
            link_next[i] = '0;
            link_prev[i] = '0;
            queued[i]    = 1'b0;
        end
        head_id = '0;
        tail_id = '0;
        depth   = '0;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_cmd   = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_idle_queue();
        test_list_edits();
        for (int p = 0; p < 3; p++) begin
            test_full_table(idle_pct[p]);
            test_random_traffic(560, idle_pct[p]);
        end
        start <= 1'b0;

        // Wait for every owed result, then a few more edges for strays.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words, checked %0d results: %0d pops with a slot, %0d on empty,",
                 n_sent, n_checked, n_pop_hit, n_pop_empty);
        $display("%0d pushes moved a queued slot, table full %0d times, %0d mismatches.",
                 n_moves, n_full, n_errors);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
